/* src/ffba_pkg.sv */
package ffba_pkg;

  // Default sizing of the arena and the segment table.
  localparam int ARENA_BYTES_DEF  = 4096;
  localparam int HEADER_BYTES_DEF = 24;
  localparam int MAX_SEGMENTS_DEF = 64;

  // Position field wide enough for the largest supported segment table.
  localparam int POS_W = 10;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TOO_LARGE = 2'd1,
    ST_NO_FIT    = 2'd2,
    ST_BAD_FREE  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_ALLOC,
    S_SCAN_FREE,
    S_FREE_NEXT,
    S_FREE_PREV,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_SET,
    CMD_INSERT,
    CMD_ABSORB
  } cmd_kind_t;

  // Command broadcast to every cell of the segment row.
  typedef struct packed {
    cmd_kind_t        kind;
    logic [POS_W-1:0] pos;
    logic             used;
  } cell_cmd_t;

endpackage

/* src/ffba_cell.sv */
module ffba_cell #(
  parameter int SW        = 13,
  parameter int IDX       = 0,
  parameter int INIT_SIZE = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ffba_pkg::cell_cmd_t cmd,
  input  logic [SW-1:0]      set_size,
  input  logic [SW-1:0]      ins_size,
  input  logic [SW-1:0]      left_size,
  input  logic               left_used,
  input  logic [SW-1:0]      right_size,
  input  logic               right_used,
  output logic [SW-1:0]      size,
  output logic               used
);
  import ffba_pkg::*;

  logic [SW-1:0]    size_r, size_nxt;
  logic             used_r, used_nxt;
  logic [POS_W-1:0] my_idx;
  logic [POS_W-1:0] pos_next;

  assign my_idx   = POS_W'(IDX);
  assign pos_next = POS_W'(cmd.pos + 1'b1);

  // Each cell updates itself from the command and its two neighbors.
  always_comb begin
    size_nxt = size_r;
    used_nxt = used_r;
    case (cmd.kind)
      CMD_SET: begin
        if (my_idx == cmd.pos) begin
          size_nxt = set_size;
          used_nxt = cmd.used;
        end
      end
      CMD_INSERT: begin
        if (my_idx == cmd.pos) begin
          size_nxt = set_size;
          used_nxt = 1'b1;
        end else if (my_idx == pos_next) begin
          size_nxt = ins_size;
          used_nxt = 1'b0;
        end else if (my_idx > cmd.pos) begin
          size_nxt = left_size;
          used_nxt = left_used;
        end
      end
      CMD_ABSORB: begin
        if (my_idx == cmd.pos) begin
          size_nxt = set_size;
          used_nxt = 1'b0;
        end else if (my_idx > cmd.pos) begin
          size_nxt = right_size;
          used_nxt = right_used;
        end
      end
      default: begin
      end
    endcase
  end

  // Only the head cell has a defined size after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
      if (IDX == 0) size_r <= SW'(INIT_SIZE);
    end else begin
      used_r <= used_nxt;
      size_r <= size_nxt;
    end
  end

  assign size = size_r;
  assign used = used_r;

endmodule

/* src/first_fit_block_allocator_unit.sv */
// An item walks the segment row one cell per cycle from start to out_valid;
// a free adds the merge steps S_FREE_NEXT and S_FREE_PREV.
// Throughput: one word at a time; busy stays high until the result cycle ends.
// Reset (synchronous, rst_n low): one free segment spans the whole arena.
// The result is shown for exactly one cycle; the receiver cannot stall it.
module first_fit_block_allocator_unit #(
  parameter int ARENA_BYTES  = ffba_pkg::ARENA_BYTES_DEF,
  parameter int HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF,
  parameter int MAX_SEGMENTS = ffba_pkg::MAX_SEGMENTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_opcode,
  input  logic [12:0] in_request_bytes,
  input  logic [11:0] in_payload_offset,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [11:0] out_granted_offset
);
  import ffba_pkg::*;

  localparam int SW   = $clog2(ARENA_BYTES + 1);
  localparam int BW   = SW + 1;
  localparam int CW   = $clog2(MAX_SEGMENTS + 1);
  localparam int IW   = $clog2(MAX_SEGMENTS);
  localparam int CMPW = ((SW > 13) ? SW : 13) + 1;
  localparam int AW   = ((BW > 12) ? BW : 12) + 1;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   idx_r, idx_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [BW-1:0]   base_r, base_nxt;
  logic [SW-1:0]   req_r, req_nxt;
  logic [11:0]     off_r, off_nxt;
  logic [CW-1:0]   pos_r, pos_nxt;
  logic [SW-1:0]   tmp_r, tmp_nxt;
  logic            prev_used_r, prev_used_nxt;
  logic [SW-1:0]   prev_size_r, prev_size_nxt;
  logic            pfree_r, pfree_nxt;
  status_t         status_r, status_nxt;
  logic [11:0]     granted_r, granted_nxt;

  cell_cmd_t       cmd;
  logic [SW-1:0]   set_size;
  logic [SW-1:0]   ins_size;

  logic [SW-1:0]   size_w [MAX_SEGMENTS];
  logic            used_w [MAX_SEGMENTS];

  logic [SW-1:0]   cur_size;
  logic            cur_used;
  logic            at_end;
  logic            fit;
  logic            too_large;
  logic            match;
  logic            split;
  logic [SW-1:0]   rest;
  logic [BW-1:0]   next_base;
  logic [BW-1:0]   hdr_addr;

  // Row of segment cells, each shifting to or from its neighbors.
  for (genvar k = 0; k < MAX_SEGMENTS; k++) begin : g_cell
    logic [SW-1:0] l_size, r_size;
    logic          l_used, r_used;
    if (k == 0) begin : g_head
      assign l_size = '0;
      assign l_used = 1'b0;
    end else begin : g_left
      assign l_size = size_w[k-1];
      assign l_used = used_w[k-1];
    end
    if (k == MAX_SEGMENTS - 1) begin : g_tail
      assign r_size = '0;
      assign r_used = 1'b0;
    end else begin : g_right
      assign r_size = size_w[k+1];
      assign r_used = used_w[k+1];
    end
    ffba_cell #(
      .SW       (SW),
      .IDX      (k),
      .INIT_SIZE(ARENA_BYTES - HEADER_BYTES)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .set_size  (set_size),
      .ins_size  (ins_size),
      .left_size (l_size),
      .left_used (l_used),
      .right_size(r_size),
      .right_used(r_used),
      .size      (size_w[k]),
      .used      (used_w[k])
    );
  end

  // Segment under the walk pointer and the decisions taken on it.
  assign cur_size  = size_w[idx_r[IW-1:0]];
  assign cur_used  = used_w[idx_r[IW-1:0]];
  assign at_end    = (idx_r >= count_r);
  assign fit       = !cur_used && (cur_size >= req_r);
  assign too_large = (CMPW'(in_request_bytes) > CMPW'(ARENA_BYTES - HEADER_BYTES));
  assign hdr_addr  = BW'(base_r + BW'(HEADER_BYTES));
  assign match     = (AW'(hdr_addr) == AW'(off_r));
  assign rest      = cur_size - req_r;
  assign split     = (rest > SW'(HEADER_BYTES)) && (count_r < CW'(MAX_SEGMENTS));
  assign next_base = BW'(base_r + BW'(HEADER_BYTES) + BW'(cur_size));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_opcode == OP_FREE) state_nxt = S_SCAN_FREE;
          else if (too_large)       state_nxt = S_DONE;
          else                      state_nxt = S_SCAN_ALLOC;
        end
      end
      S_SCAN_ALLOC: begin
        if (at_end || fit) state_nxt = S_DONE;
      end
      S_SCAN_FREE: begin
        if (at_end) state_nxt = S_DONE;
        else if (match) state_nxt = cur_used ? S_FREE_NEXT : S_DONE;
      end
      S_FREE_NEXT: state_nxt = S_FREE_PREV;
      S_FREE_PREV: state_nxt = S_DONE;
      S_DONE:      state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  // Datapath registers and the command to the cell row.
  always_comb begin
    idx_nxt       = idx_r;
    count_nxt     = count_r;
    base_nxt      = base_r;
    req_nxt       = req_r;
    off_nxt       = off_r;
    pos_nxt       = pos_r;
    tmp_nxt       = tmp_r;
    prev_used_nxt = prev_used_r;
    prev_size_nxt = prev_size_r;
    pfree_nxt     = pfree_r;
    status_nxt    = status_r;
    granted_nxt   = granted_r;
    cmd.kind      = CMD_NONE;
    cmd.pos       = POS_W'(idx_r);
    cmd.used      = 1'b0;
    set_size      = cur_size;
    ins_size      = SW'(rest - SW'(HEADER_BYTES));
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          idx_nxt       = '0;
          base_nxt      = '0;
          req_nxt       = SW'(in_request_bytes);
          off_nxt       = in_payload_offset;
          granted_nxt   = '0;
          prev_used_nxt = 1'b1;
          status_nxt    = (in_opcode == OP_ALLOC && too_large) ? ST_TOO_LARGE : ST_OK;
        end
      end
      S_SCAN_ALLOC: begin
        if (at_end) begin
          status_nxt = ST_NO_FIT;
        end else if (fit) begin
          granted_nxt = hdr_addr[11:0];
          if (split) begin
            cmd.kind  = CMD_INSERT;
            set_size  = req_r;
            count_nxt = CW'(count_r + 1'b1);
          end else begin
            cmd.kind = CMD_SET;
            cmd.used = 1'b1;
          end
        end else begin
          idx_nxt  = CW'(idx_r + 1'b1);
          base_nxt = next_base;
        end
      end
      S_SCAN_FREE: begin
        if (at_end) begin
          status_nxt = ST_BAD_FREE;
        end else if (match) begin
          if (!cur_used) begin
            status_nxt = ST_BAD_FREE;
          end else begin
            cmd.kind  = CMD_SET;
            pos_nxt   = idx_r;
            tmp_nxt   = cur_size;
            pfree_nxt = !prev_used_r;
            idx_nxt   = CW'(idx_r + 1'b1);
          end
        end else begin
          prev_used_nxt = cur_used;
          prev_size_nxt = cur_size;
          idx_nxt       = CW'(idx_r + 1'b1);
          base_nxt      = next_base;
        end
      end
      S_FREE_NEXT: begin
        // Merge with the following segment when it is free.
        if (!at_end && !cur_used) begin
          cmd.kind  = CMD_ABSORB;
          cmd.pos   = POS_W'(pos_r);
          set_size  = SW'(tmp_r + SW'(HEADER_BYTES) + cur_size);
          tmp_nxt   = set_size;
          count_nxt = CW'(count_r - 1'b1);
        end
      end
      S_FREE_PREV: begin
        // Fold the freed segment into a free predecessor.
        if (pfree_r) begin
          cmd.kind  = CMD_ABSORB;
          cmd.pos   = POS_W'(pos_r - 1'b1);
          set_size  = SW'(prev_size_r + SW'(HEADER_BYTES) + tmp_r);
          count_nxt = CW'(count_r - 1'b1);
        end
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= CW'(1);
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // Working registers of the walk.
  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    base_r      <= base_nxt;
    req_r       <= req_nxt;
    off_r       <= off_nxt;
    pos_r       <= pos_nxt;
    tmp_r       <= tmp_nxt;
    prev_used_r <= prev_used_nxt;
    prev_size_r <= prev_size_nxt;
    pfree_r     <= pfree_nxt;
    status_r    <= status_nxt;
    granted_r   <= granted_nxt;
  end

  // Result word and handshake outputs.
  assign busy               = (state_r != S_IDLE);
  assign out_valid          = (state_r == S_DONE);
  assign out_status         = status_r;
  assign out_granted_offset = (status_r == ST_OK) ? granted_r : 12'd0;

`ifndef SYNTHESIS
  a_count_range : assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) && (count_r <= CW'(MAX_SEGMENTS)))
    else $error("segment count out of range");

  a_accept_busy : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  a_count_idle : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |=> $stable(count_r))
    else $error("segment count changed while idle");

  a_result_once : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result shown for more than one cycle");
`endif

endmodule
